// ----- sv/aars_pkg.sv -----
// Shared types, constants, the control store and saturation for the reverb stage.
`default_nettype none
package aars_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned ADDR_W   = 17;
  localparam int unsigned DEPTH    = 1 << ADDR_W;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned FF_W     = COEF_W + 1;           // 1-c reaches 1.0
  localparam int unsigned MUL_W    = SAMPLE_W + FF_W + 1;  // signed product
  localparam int unsigned PROD_W   = SAMPLE_W + FF_W;      // product register
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned RND_W    = SUM_W - COEF_W;
  localparam int unsigned RES_W    = RND_W + 1;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W   = 4;

  localparam logic [ADDR_W-1:0] DELAY_LENGTH_RST = ADDR_W'(12000);
  localparam logic [COEF_W-1:0] ABS_GAIN_RST     = COEF_W'(45875);
  localparam logic [COEF_W-1:0] LP_COEF_RST      = COEF_W'(39322);
  localparam logic [COEF_W-1:0] AP_GAIN_RST      = COEF_W'(40503);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH = 8'd0,
    REG_ABS_GAIN     = 8'd1,
    REG_LP_COEF      = 8'd2,
    REG_AP_GAIN      = 8'd3
  } cfg_reg_e;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {SA_D, SA_LP, SA_A, SA_V} mul_a_e;
  typedef enum logic [1:0] {SB_FF, SB_C, SB_AG, SB_G} mul_b_e;
  typedef enum logic [1:0] {AD_ZERO, AD_MEM, AD_A} add_e;
  typedef enum logic [2:0] {DS_NONE, DS_LP, DS_MEM, DS_A, DS_V, DS_OUT} dst_e;
  typedef enum logic [1:0] {JC_NEVER, JC_NO_INPUT, JC_OUT_FULL, JC_ALWAYS} jc_e;

  typedef struct packed {
    logic   mul_en;
    mul_a_e mul_a;
    mul_b_e mul_b;
    add_e   add_sel;
    logic   post_sub;
    dst_e   dst;
    logic   commit;   // write v, bump write index, load output word
    logic   last;     // fall through to step 0
    jc_e    jmp_cond;
    step_t  jmp_to;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    mul_en: 1'b0, mul_a: SA_D, mul_b: SB_FF, add_sel: AD_ZERO, post_sub: 1'b0,
    dst: DS_NONE, commit: 1'b0, last: 1'b0, jmp_cond: JC_NEVER, jmp_to: '0
  };

  // Microprogram: one multiply into the product register, processed a step later.
  function automatic ctrl_t prog_rom(input step_t step);
    ctrl_t c;
    c = CTRL_NOP;
    case (step)
      4'd0: begin  // wait for a sample; the delay read is issued meanwhile
        c.jmp_cond = JC_NO_INPUT;
        c.jmp_to   = 4'd0;
      end
      4'd1: begin  // d * (1-c)
        c.mul_en = 1'b1; c.mul_a = SA_D; c.mul_b = SB_FF;
      end
      4'd2: begin  // lp = sat(rnd(d*(1-c) + mem))
        c.add_sel = AD_MEM; c.dst = DS_LP;
      end
      4'd3: begin  // lp * c
        c.mul_en = 1'b1; c.mul_a = SA_LP; c.mul_b = SB_C;
      end
      4'd4: begin  // lp * absorbent gain, mem = rnd(lp*c)
        c.mul_en = 1'b1; c.mul_a = SA_LP; c.mul_b = SB_AG;
        c.dst = DS_MEM;
      end
      4'd5: begin
        c.dst = DS_A;
      end
      4'd6: begin  // a * g
        c.mul_en = 1'b1; c.mul_a = SA_A; c.mul_b = SB_G;
      end
      4'd7: begin  // v = sat(x - rnd(a*g))
        c.post_sub = 1'b1; c.dst = DS_V;
      end
      4'd8: begin  // v * g
        c.mul_en = 1'b1; c.mul_a = SA_V; c.mul_b = SB_G;
      end
      4'd9: begin  // out = sat(rnd(v*g) + a), hold while the output word is stuck
        c.add_sel = AD_A; c.dst = DS_OUT; c.commit = 1'b1; c.last = 1'b1;
        c.jmp_cond = JC_OUT_FULL; c.jmp_to = 4'd9;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] smax;
    logic signed [RES_W-1:0] smin;
    smax = RES_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
    smin = RES_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (v > smax) begin
      return smax[SAMPLE_W-1:0];
    end else if (v < smin) begin
      return smin[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/aars_dp.sv -----
// Datapath of the reverb stage: shared multiplier, round/add/saturate unit, working registers.
`default_nettype none
module aars_dp
  import aars_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ctrl_t                       ctrl_i,
  input  wire logic signed [SAMPLE_W-1:0]  d_i,
  input  wire logic signed [SAMPLE_W-1:0]  x_i,
  input  wire logic        [COEF_W-1:0]    abs_gain_i,
  input  wire logic        [COEF_W-1:0]    lp_coef_i,
  input  wire logic        [COEF_W-1:0]    ap_gain_i,
  output logic signed      [SAMPLE_W-1:0]  v_o,
  output logic signed      [SAMPLE_W-1:0]  post_o
);

  logic signed [SAMPLE_W-1:0] lp_q, a_q, v_q, mem_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAMPLE_W-1:0] op_a;
  logic        [FF_W-1:0]     op_b;
  logic        [FF_W-1:0]     ff;
  logic signed [MUL_W-1:0]    prod_full;
  logic signed [SAMPLE_W-1:0] addend;
  logic signed [SUM_W-1:0]    sum;
  logic signed [RND_W-1:0]    rnd;
  logic signed [RES_W-1:0]    pre;

  assign ff = FF_W'(1 << COEF_W) - FF_W'(lp_coef_i);

  always_comb begin
    case (ctrl_i.mul_a)
      SA_D:    op_a = d_i;
      SA_LP:   op_a = lp_q;
      SA_A:    op_a = a_q;
      SA_V:    op_a = v_q;
      default: op_a = d_i;
    endcase
    case (ctrl_i.mul_b)
      SB_FF:   op_b = ff;
      SB_C:    op_b = FF_W'(lp_coef_i);
      SB_AG:   op_b = FF_W'(abs_gain_i);
      SB_G:    op_b = FF_W'(ap_gain_i);
      default: op_b = ff;
    endcase
    case (ctrl_i.add_sel)
      AD_MEM:  addend = mem_q;
      AD_A:    addend = a_q;
      default: addend = '0;
    endcase
  end

  assign prod_full = MUL_W'(op_a) * MUL_W'(signed'({1'b0, op_b}));

  // round half up: floor((p + addend*2^16 + 2^15) / 2^16)
  assign sum = SUM_W'(prod_q) + (SUM_W'(addend) <<< COEF_W)
             + SUM_W'(signed'({1'b0, 1'b1, {(COEF_W-1){1'b0}}}));
  assign rnd = sum[SUM_W-1:COEF_W];
  assign pre = ctrl_i.post_sub ? (RES_W'(x_i) - RES_W'(rnd)) : RES_W'(rnd);
  assign post_o = sat_sample(pre);
  assign v_o    = v_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    case (ctrl_i.dst)
      DS_LP:   lp_q <= post_o;
      DS_A:    a_q  <= post_o;
      DS_V:    v_q  <= post_o;
      default: ;
    endcase
  end

  // lowpass memory is state and persists between samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= '0;
    end else if (ctrl_i.dst == DS_MEM) begin
      mem_q <= post_o;
    end
  end

endmodule
`default_nettype wire

// ----- sv/absorbent_allpass_reverb_stage.sv -----
// Top level of the absorbent all-pass reverb stage: sequencer, delay memory, ports.
//
// Channel   Dir  Handshake                      Word
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[23:0] sample_in
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[23:0] sample_out
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// A 10-step microprogram drives one 24x17 multiplier,
// each product registered and rounded/saturated the step after.
// The result lands in an output register; the next sample is taken right after,
// so a stalled result only holds the last step until the word is taken.
// Reset clears the write index and the lowpass memory and reloads the register
// defaults; the delay memory is not swept: reads of never written entries return
// zero from a wrap flag and the write index (writes run in address order).
`default_nettype none
module absorbent_allpass_reverb_stage
  import aars_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input samples
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample_in
  // output samples
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]        m_axis_tdata,   // [23:0] sample_out
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers
  logic [ADDR_W-1:0] delay_len_q;
  logic [COEF_W-1:0] abs_gain_q, lp_coef_q, ap_gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= DELAY_LENGTH_RST;
      abs_gain_q  <= ABS_GAIN_RST;
      lp_coef_q   <= LP_COEF_RST;
      ap_gain_q   <= AP_GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DELAY_LENGTH: delay_len_q <= cfg_data_i[ADDR_W-1:0];
        REG_ABS_GAIN:     abs_gain_q  <= cfg_data_i[COEF_W-1:0];
        REG_LP_COEF:      lp_coef_q   <= cfg_data_i[COEF_W-1:0];
        REG_AP_GAIN:      ap_gain_q   <= cfg_data_i[COEF_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // sequencer
  step_t pc_q, pc_d;
  ctrl_t rom_word, ctrl;
  logic  jmp_taken, hold, out_full, in_fire;

  assign rom_word = prog_rom(pc_q);
  assign out_full = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    case (rom_word.jmp_cond)
      JC_NO_INPUT: jmp_taken = !s_axis_tvalid;
      JC_OUT_FULL: jmp_taken = out_full;
      JC_ALWAYS:   jmp_taken = 1'b1;
      default:     jmp_taken = 1'b0;
    endcase
  end

  // a wait step does nothing while it spins on itself
  assign hold = jmp_taken && (rom_word.jmp_cond != JC_ALWAYS);
  assign ctrl = hold ? CTRL_NOP : rom_word;

  always_comb begin
    if (jmp_taken) begin
      pc_d = rom_word.jmp_to;
    end else if (rom_word.last) begin
      pc_d = '0;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign s_axis_tready = (pc_q == '0);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  logic signed [SAMPLE_W-1:0] x_q;
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= s_axis_tdata;
    end
  end

  // delay memory: write index, read index and fill tracking
  logic [ADDR_W-1:0]   wi_q, ri;
  logic                wrapped_q;
  logic [SAMPLE_W-1:0] dstore [DEPTH];
  logic [SAMPLE_W-1:0] rd_q;
  logic signed [SAMPLE_W-1:0] d_gated, v_val, post_val;

  assign ri = wi_q - delay_len_q;  // wraps modulo the memory depth

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      dstore[wi_q] <= v_val;
    end
    rd_q <= dstore[ri];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (ctrl.commit) begin
      wi_q <= wi_q + ADDR_W'(1);
      if (wi_q == '1) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // entries not yet written since reset read as zero
  assign d_gated = (wrapped_q || (ri < wi_q)) ? signed'(rd_q) : '0;

  aars_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .d_i        (d_gated),
    .x_i        (x_q),
    .abs_gain_i (abs_gain_q),
    .lp_coef_i  (lp_coef_q),
    .ap_gain_i  (ap_gain_q),
    .v_o        (v_val),
    .post_o     (post_val)
  );

  // output word register
  logic                valid_q;
  logic [SAMPLE_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.dst == DS_OUT) begin
      out_q <= post_val;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// ----- tb/absorbent_allpass_reverb_stage_tb.sv -----
// Self-checking testbench for the absorbent all-pass reverb stage.
`timescale 1ns / 1ps
module absorbent_allpass_reverb_stage_tb
  import aars_pkg::*;
();

  // Directed table first, then random phases. Each phase reprograms every
  // register while the stage is idle and streams random samples through it.
  // Expected words come from a bit-accurate predictor with its own delay line,
  // write pointer and damping memory, unless a directed row gives its own.

  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam longint      S_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint      S_MIN = -(longint'(1) << (SAMPLE_W - 1));
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;  // no register here

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   sample;
    bit                    has_exp;
    logic [SAMPLE_W-1:0]   exp_out;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  absorbent_allpass_reverb_stage dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [23:0] sample_in
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [23:0] sample_out
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state: delay line (zero at start), write pointer, damping memory
  bit signed [SAMPLE_W-1:0] echo_mem [DEPTH];
  logic [ADDR_W-1:0]        echo_wr_ptr = '0;
  longint                   damp_mem = 0;

  // Register mirror, reset values
  logic [ADDR_W-1:0] dly_len  = DELAY_LENGTH_RST;
  logic [COEF_W-1:0] absorb_g = ABS_GAIN_RST;
  logic [COEF_W-1:0] damp_c   = LP_COEF_RST;
  logic [COEF_W-1:0] ap_g     = AP_GAIN_RST;

  logic [SAMPLE_W-1:0] pending_out_q [$];
  dir_row_t            dir_rows [$];
  logic [SAMPLE_W-1:0] want_out;

  int unsigned fail_count    = 0;
  int unsigned samples_sent  = 0;
  int unsigned words_checked = 0;
  int unsigned clip_count    = 0;
  int unsigned cfg_writes    = 0;
  bit          feed_steady   = 1'b0;  // no gaps on the input side
  bit          sink_steady   = 1'b0;  // no stalls on the output side

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog, well above the slowest legal run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Q0.16 product rounded half up: floor((v + 32768) / 65536)
  function automatic longint q16_round(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clamp_sample(input longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] predict_reverb_out(input logic [SAMPLE_W-1:0] s);
    longint x, d, ff, lp_raw, lp, a, v_raw, v, o_raw, o;
    logic [ADDR_W-1:0] rd_ptr;
    x  = longint'($signed(s));
    // depth is a power of two, so the wrap is plain truncation; zero delay
    // reads the entry about to be overwritten
    rd_ptr = echo_wr_ptr - dly_len;
    d  = longint'(echo_mem[rd_ptr]);
    ff = 65536 - longint'(damp_c);
    lp_raw = q16_round(ff * d + damp_mem * 65536);
    lp = clamp_sample(lp_raw);
    damp_mem = clamp_sample(q16_round(lp * longint'(damp_c)));
    a  = clamp_sample(q16_round(lp * longint'(absorb_g)));
    v_raw = x - q16_round(a * longint'(ap_g));
    v  = clamp_sample(v_raw);
    o_raw = q16_round(v * longint'(ap_g)) + a;
    o  = clamp_sample(o_raw);
    if (lp != lp_raw || v != v_raw || o != o_raw) begin
      clip_count++;
    end
    echo_mem[echo_wr_ptr] = v[SAMPLE_W-1:0];
    echo_wr_ptr = echo_wr_ptr + ADDR_W'(1);
    return o[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- random picks

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return SAMPLE_W'($urandom());
    if (r < 48) return {1'b0, {(SAMPLE_W-1){1'b1}}};
    if (r < 55) return {1'b1, {(SAMPLE_W-1){1'b0}}};
    if (r < 85) return SAMPLE_W'(int'($urandom_range(0, 8192)) - 4096);
    return {$urandom_range(0, 1) ? 2'b10 : 2'b01, (SAMPLE_W-2)'($urandom())};
  endfunction

  // Unused upper bits carry junk; the stage masks them
  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    int unsigned r;
    logic [ADDR_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 55)      len = ADDR_W'($urandom_range(1, 40));
    else if (r < 70) len = ADDR_W'($urandom_range(41, 1200));
    else if (r < 80) len = '0;
    else if (r < 90) len = ADDR_W'($urandom_range(65536, 131071));
    else             len = ADDR_W'($urandom_range(1, 131071));
    return ($urandom() & ~CFG_DATA_W'(DEPTH - 1)) | CFG_DATA_W'(len);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    int unsigned r;
    logic [COEF_W-1:0] c;
    r = $urandom_range(0, 99);
    if (r < 15)      c = '0;
    else if (r < 30) c = '1;
    else             c = COEF_W'($urandom());
    return {CFG_DATA_W'($urandom()) >> COEF_W << COEF_W} | CFG_DATA_W'(c);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);  // keeps the next raise of valid in a later step
    case (idx)
      REG_DELAY_LENGTH: dly_len  = data[ADDR_W-1:0];
      REG_ABS_GAIN:     absorb_g = data[COEF_W-1:0];
      REG_LP_COEF:      damp_c   = data[COEF_W-1:0];
      REG_AP_GAIN:      ap_g     = data[COEF_W-1:0];
      default: ;        // unmapped index, nothing changes
    endcase
    cfg_writes++;
  endtask

  // Push one sample word; a typed-in expectation replaces the predicted one,
  // but the predictor still runs to keep its state in step.
  task automatic feed_sample(input logic [SAMPLE_W-1:0] s, input bit has_exp,
                             input logic [SAMPLE_W-1:0] exp_out);
    int unsigned gap;
    logic [SAMPLE_W-1:0] pred;
    gap = feed_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_reverb_out(s);
    pending_out_q.push_back(has_exp ? exp_out : pred);
    samples_sent++;
  endtask

  // Idle the input and let every outstanding word come out before a register write
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_sample(input logic [SAMPLE_W-1:0] s, input bit has_exp,
                            input logic [SAMPLE_W-1:0] exp_out);
    dir_row_t row;
    row = '{kind: ROW_SAMPLE, idx: '0, data: '0, sample: s, has_exp: has_exp, exp_out: exp_out};
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, sample: '0, has_exp: 1'b0, exp_out: '0};
    dir_rows.push_back(row);
  endtask

  // Output side: ready held for a while, then a random stall unless sink_steady
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      stall = sink_steady ? 0 : pick_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out_q.size() == 0) begin
        $error("sample_out: no word expected, got %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        want_out = pending_out_q.pop_front();
        if (m_axis_tdata !== want_out) begin
          $error("sample_out: expected %0d, got %0d", $signed(want_out), $signed(m_axis_tdata));
          fail_count++;
        end
        words_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;

    // Reset config, delay line still empty: lp = a = 0, so out = round(x*g)
    add_sample(24'd0,                  1'b1, 24'd0);
    add_sample(24'd1,                  1'b1, 24'd1);
    add_sample(24'(-1),                1'b1, 24'(-1));
    add_sample(24'h7FFFFF,             1'b1, 24'd5184383);
    add_sample(24'h800000,             1'b1, 24'(-5184384));
    add_sample(24'h555555,             1'b0, '0);
    add_sample(24'hAAAAAA,             1'b0, '0);
    // One-sample delay, no damping, gains at full scale: feedback saturates
    add_cfg(REG_DELAY_LENGTH, 32'd1);
    add_cfg(REG_LP_COEF,      32'd0);
    add_cfg(REG_ABS_GAIN,     32'hFFFF);
    add_cfg(REG_AP_GAIN,      32'hFFFF);
    add_sample(24'h7FFFFF,             1'b0, '0);
    add_sample(24'h7FFFFF,             1'b0, '0);
    add_sample(24'h800000,             1'b0, '0);
    add_sample(24'h800000,             1'b0, '0);
    add_sample(24'h7FFFFF,             1'b0, '0);
    // Heaviest damping (feedforward 1/65536), all-pass gain off
    add_cfg(REG_LP_COEF,      32'hFFFF);
    add_cfg(REG_AP_GAIN,      32'd0);
    add_cfg(REG_DELAY_LENGTH, 32'd2);
    add_sample(24'd123456,             1'b0, '0);
    add_sample(24'(-654321),           1'b0, '0);
    add_sample(24'h7FFFFF,             1'b0, '0);
    // Zero delay through masking (2^17), absorbent gain off, unmapped index
    add_cfg(REG_ABS_GAIN,     32'hABCD_0000);
    add_cfg(REG_AP_GAIN,      32'h0000_8000);
    add_cfg(REG_DELAY_LENGTH, 32'h0002_0000);
    add_cfg(REG_UNMAPPED,     32'hFFFF_FFFF);
    add_sample(24'd1000,               1'b0, '0);
    add_sample(24'(-1000),             1'b0, '0);
    // Longest delay, all upper bits set
    add_cfg(REG_DELAY_LENGTH, 32'hFFFF_FFFF);
    add_cfg(REG_ABS_GAIN,     32'd45875);
    add_sample(24'h400000,             1'b0, '0);
    add_sample(24'hC00000,             1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        feed_sample(dir_rows[i].sample, dir_rows[i].has_exp, dir_rows[i].exp_out);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_idle();
      write_reg(REG_DELAY_LENGTH, pick_delay());
      write_reg(REG_ABS_GAIN,     pick_coef());
      write_reg(REG_LP_COEF,      pick_coef());
      write_reg(REG_AP_GAIN,      pick_coef());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), $urandom());
      end
      feed_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        feed_sample(rand_sample(), 1'b0, '0);
      end
    end

    settle_idle();
    $display("Run covered %0d samples, %0d output words checked, %0d register writes",
             samples_sent, words_checked, cfg_writes);
    $display("over %0d random settings; %0d samples hit saturation",
             RAND_PHASES, clip_count);
    if (fail_count == 0 && pending_out_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- absorbent_allpass_reverb_stage.f -----
sv/aars_pkg.sv
sv/aars_dp.sv
sv/absorbent_allpass_reverb_stage.sv
tb/absorbent_allpass_reverb_stage_tb.sv
